// ----- hw/rtl/qwn_pkg.sv -----
// Package for the query whitespace normalizer: character codes, mode codes,
// front/back bundle type and the per-character rewrite functions.
// No dependencies.
package qwn_pkg;

   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_CARET   = 8'h5E;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_BAR     = 8'h7C;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;

   localparam logic [2:0] MODE_NORMAL = 3'd0;
   localparam logic [2:0] MODE_DIGITS = 3'd1;
   localparam logic [2:0] MODE_QUOTE  = 3'd2;

   localparam int unsigned MAX_RES = 4;

   // stage-two state
   typedef struct packed {
      logic [7:0] held_char;
      logic       held_valid;
      logic [2:0] mode;
   } s2_state_type;

   // stage-two state plus the bytes emitted so far for one beat
   typedef struct packed {
      s2_state_type          st;
      logic [3:0][7:0]       chars;
      logic [2:0]            count;
   } s2_result_type;

   // one queue entry: all results caused by one input beat
   typedef struct packed {
      logic [3:0][7:0] chars;
      logic [1:0]      last_idx;
      logic            marker;   // empty final marker, no real byte
      logic            last;
   } bundle_type;

   function automatic logic is_open(input logic [7:0] c);
      return c == CH_LPAREN || c == CH_LBRACK || c == CH_LBRACE || c == CH_QUOTE;
   endfunction

   function automatic logic is_close(input logic [7:0] c);
      return c == CH_RPAREN || c == CH_RBRACK || c == CH_RBRACE || c == CH_QUOTE;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic s2_result_type emit(input s2_result_type r, input logic [7:0] c);
      s2_result_type o;
      o = r;
      if (o.count < 3'(MAX_RES)) begin
         o.chars[o.count[1:0]] = c;
         o.count = 3'(o.count + 3'd1);
      end
      return o;
   endfunction

   // operator spacing rewrite with one byte of lookahead
   function automatic s2_result_type stage_two(input s2_result_type r, input logic [7:0] x);
      s2_result_type o;
      logic [7:0]    h;
      logic          done;
      o    = r;
      done = 1'b0;
      h    = o.st.held_char;
      if (o.st.held_valid) begin
         o.st.held_valid = 1'b0;
         if (h == CH_BANG || h == CH_BAR || h == CH_LPAREN || h == CH_LBRACK ||
             h == CH_LBRACE || h == CH_RBRACE) begin
            if (x == CH_SPACE) done = 1'b1;
         end else if (h == CH_RPAREN || h == CH_RBRACK) begin
            if (x != CH_SPACE && x != CH_BAR) o = emit(o, CH_SPACE);
         end else if (h == CH_CARET) begin
            o.st.mode = MODE_DIGITS;
            if (x == CH_SPACE) done = 1'b1;
         end else if (h == CH_SPACE) begin
            if (!is_close(x)) o = emit(o, CH_SPACE);
         end else begin
            if (is_open(x) || x == CH_BANG) o = emit(o, CH_SPACE);
         end
      end
      if (!done) begin
         if (o.st.mode == MODE_QUOTE) begin
            o = emit(o, x);
            if (x == CH_QUOTE) o.st.mode = MODE_NORMAL;
         end else if (o.st.mode == MODE_DIGITS && is_digit(x)) begin
            o = emit(o, x);
         end else begin
            if (o.st.mode == MODE_DIGITS && is_open(x)) o = emit(o, CH_SPACE);
            o.st.mode = MODE_NORMAL;
            if (x == CH_SPACE) begin
               o.st.held_char  = x;
               o.st.held_valid = 1'b1;
            end else begin
               o = emit(o, x);
               if (x == CH_QUOTE) begin
                  o.st.mode = MODE_QUOTE;
               end else begin
                  o.st.held_char  = x;
                  o.st.held_valid = 1'b1;
               end
            end
         end
      end
      return o;
   endfunction

endpackage

// ----- hw/rtl/query_whitespace_normalizer_top.sv -----
// Top level of the query whitespace normalizer.
// Uses qwn_pkg, qwn_front, qwn_queue and qwn_back.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_char_in[7:0], req_end_of_query
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_char_out[7:0], rsp_char_valid,
//          |           |                      | rsp_last_out
//
// The front end takes one raw byte per cycle while the queue is not full and
// does all per-byte work in that cycle; each beat yields zero to four result
// bytes (plus an empty marker at end of query when nothing else came out).
// The back end drains one result per cycle while the output is not stalled;
// the queue of QUEUE_DEPTH bundles absorbs bursts. Reset is synchronous,
// active high, and clears the query state, the queue and the output valid.
// req_stall is high only while the queue is full; rsp_stall holds a valid
// output register, and the back end then stops popping.
module query_whitespace_normalizer_top import qwn_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   input  logic       req_end_of_query,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_char_out,
   output logic       rsp_char_valid,
   output logic       rsp_last_out
);

   logic       push, pop, full, not_empty;
   bundle_type push_data, head;

   // classify and rewrite, one byte per cycle while the queue is not full
   qwn_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_char_in      (req_char_in),
      .req_end_of_query (req_end_of_query),
      .queue_full       (full),
      .req_stall        (req_stall),
      .push             (push),
      .push_data        (push_data)
   );

   // decouples the byte-rate front from the result-rate back
   qwn_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head      (head)
   );

   // serialize each bundle onto the rsp channel
   qwn_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (not_empty),
      .head           (head),
      .pop            (pop),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_char_out   (rsp_char_out),
      .rsp_char_valid (rsp_char_valid),
      .rsp_last_out   (rsp_last_out)
   );

endmodule

// ----- hw/rtl/qwn_front.sv -----
// Front end: accepts raw beats, runs the space collapse and the operator
// rewrite, and pushes one bundle per beat with results or a query end. Uses qwn_pkg.
module qwn_front import qwn_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_char_in,
   input  logic       req_end_of_query,
   input  logic       queue_full,
   output logic       req_stall,
   output logic       push,
   output bundle_type push_data
);

   logic          space_pending_ff, space_pending_in;
   logic          after_bar_ff, after_bar_in;
   s2_state_type  s2_ff, s2_in;
   s2_result_type work;
   logic          accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      space_pending_in = space_pending_ff;
      after_bar_in     = after_bar_ff;
      work.st          = s2_ff;
      work.chars       = '0;
      work.count       = '0;
      if (req_char_in == CH_SPACE) begin
         if (!after_bar_ff) space_pending_in = 1'b1;
      end else if (req_char_in == CH_BAR) begin
         space_pending_in = 1'b0;
         after_bar_in     = 1'b1;
         work             = stage_two(work, req_char_in);
      end else begin
         if (space_pending_ff) work = stage_two(work, CH_SPACE);
         space_pending_in = 1'b0;
         after_bar_in     = 1'b0;
         work             = stage_two(work, req_char_in);
      end
      if (req_end_of_query) begin
         if (work.st.mode == MODE_QUOTE) work = emit(work, CH_QUOTE);
         space_pending_in = 1'b0;
         after_bar_in     = 1'b0;
         work.st          = '0;
      end
      s2_in = work.st;

      push                = accept && (work.count != 3'd0 || req_end_of_query);
      push_data.chars     = work.chars;
      push_data.marker    = (work.count == 3'd0);
      push_data.last_idx  = (work.count == 3'd0) ? 2'd0 : 2'(work.count - 3'd1);
      push_data.last      = req_end_of_query;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         space_pending_ff <= 1'b0;
         after_bar_ff     <= 1'b0;
         s2_ff            <= '0;
      end else if (accept) begin
         space_pending_ff <= space_pending_in;
         after_bar_ff     <= after_bar_in;
         s2_ff            <= s2_in;
      end
   end

endmodule

// ----- hw/rtl/qwn_queue.sv -----
// Bundle queue between front and back end, register based.
// Uses qwn_pkg for the bundle type.
module qwn_queue import qwn_pkg::*; #(
   parameter int unsigned DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_data,
   input  logic       pop,
   output logic       full,
   output logic       not_empty,
   output bundle_type head
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   bundle_type      entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) count_in = CW'(count_ff + 1'b1);
      else if (pop && !push) count_in = CW'(count_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ----- hw/rtl/qwn_back.sv -----
// Back end: walks the head bundle one result per cycle, while the output
// is not stalled, into the output register. Uses qwn_pkg for the bundle type.
module qwn_back import qwn_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  bundle_type head,
   output logic       pop,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output logic [7:0] rsp_char_out,
   output logic       rsp_char_valid,
   output logic       rsp_last_out
);

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] char_ff, char_in;
   logic       cvalid_ff, cvalid_in;
   logic       last_ff, last_in;
   logic [1:0] idx_ff, idx_in;
   logic       load, at_end;

   assign load   = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign at_end = (idx_ff == head.last_idx);
   assign pop    = load && at_end;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      idx_in       = idx_ff;
      char_in      = char_ff;
      cvalid_in    = cvalid_ff;
      last_in      = last_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (load) begin
         rsp_valid_in = 1'b1;
         char_in      = head.marker ? 8'h00 : head.chars[idx_ff];
         cvalid_in    = !head.marker;
         last_in      = head.last && at_end;
         idx_in       = at_end ? 2'd0 : 2'(idx_ff + 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff   <= char_in;
      cvalid_ff <= cvalid_in;
      last_ff   <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_char_out   = char_ff;
   assign rsp_char_valid = cvalid_ff;
   assign rsp_last_out   = last_ff;

endmodule
